// ===== design/motor_link_init_sequencer_core_assert.svh =====
// assertion macros shared by the link init sequencer
`ifndef MOTOR_LINK_INIT_SEQUENCER_CORE_ASSERT_SVH
`define MOTOR_LINK_INIT_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MLIS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlis assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define MLIS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlis assertion failed");

`endif

// ===== design/mlis_pkg.sv =====
package mlis_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_TYPE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_DIAM = 3'd5;

	// register reset values
	localparam logic [15:0] GAP_RST        = 16'd100;
	localparam logic [15:0] TIMEOUT_RST    = 16'd1000;
	localparam logic [7:0]  MOTOR_TYPE_RST = 8'd1;
	localparam logic [15:0] LINE_COUNT_RST = 16'd11;
	localparam logic [15:0] GEAR_RATIO_RST = 16'd30;
	localparam logic [15:0] WHEEL_DIAM_RST = 16'd65;

	// item kinds
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	// reply frame kinds
	localparam logic [3:0] FK_OK      = 4'd1;
	localparam logic [3:0] FK_NACK    = 4'd2;
	localparam logic [3:0] FK_PULSES  = 4'd3;
	localparam logic [3:0] FK_SPEEDS  = 4'd4;
	localparam logic [3:0] FK_BATTERY = 4'd5;
	localparam logic [3:0] FK_ALL     = 4'd6;

	// sequence steps
	localparam logic [3:0] STEP_PROBE    = 4'd0;
	localparam logic [3:0] STEP_TYPE     = 4'd1;
	localparam logic [3:0] STEP_LINES    = 4'd2;
	localparam logic [3:0] STEP_GEAR     = 4'd3;
	localparam logic [3:0] STEP_DIAMETER = 4'd4;
	localparam logic [3:0] STEP_FLASH    = 4'd5;
	localparam logic [3:0] STEP_VOLTAGE  = 4'd6;
	localparam logic [3:0] STEP_UPLOAD   = 4'd7;
	localparam logic [3:0] STEP_RUNNING  = 4'd8;
	localparam logic [3:0] STEP_FAILED   = 4'd9;

	// reply waits
	localparam logic [2:0] WAIT_NONE     = 3'd0;
	localparam logic [2:0] WAIT_CFG_OK   = 3'd1;
	localparam logic [2:0] WAIT_FLASH_OK = 3'd2;
	localparam logic [2:0] WAIT_BATTERY  = 3'd3;
	localparam logic [2:0] WAIT_UPLOAD   = 3'd4;

	// reported events
	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_ADVANCED  = 3'd1;
	localparam logic [2:0] EV_FAIL_NACK = 3'd2;
	localparam logic [2:0] EV_FAIL_TX   = 3'd3;
	localparam logic [2:0] EV_TIMEOUT   = 3'd4;

	// command codes
	localparam logic [2:0] CMD_ZERO_PWM     = 3'd0;
	localparam logic [2:0] CMD_TYPE         = 3'd1;
	localparam logic [2:0] CMD_LINES        = 3'd2;
	localparam logic [2:0] CMD_GEAR         = 3'd3;
	localparam logic [2:0] CMD_DIAMETER     = 3'd4;
	localparam logic [2:0] CMD_READ_FLASH   = 3'd5;
	localparam logic [2:0] CMD_READ_VOLTAGE = 3'd6;
	localparam logic [2:0] CMD_UPLOAD       = 3'd7;

	localparam logic [15:0] UPLOAD_FLAGS = 16'd6;

	typedef struct packed {
		logic [15:0] gap;
		logic [15:0] timeout;
		logic [7:0]  motor_type;
		logic [15:0] line_count;
		logic [15:0] gear_ratio;
		logic [15:0] wheel_diameter;
	} cfg_t;

	typedef struct packed {
		logic [31:0] cur_time;
		logic [31:0] next_time;
		logic [31:0] deadline;
		logic [3:0]  step;
		logic [2:0]  waiting;
		logic [15:0] probes;
	} state_t;

	typedef struct packed {
		logic        cmd_valid;
		logic [2:0]  cmd_code;
		logic [15:0] cmd_arg;
		logic [3:0]  step_now;
		logic [2:0]  wait_now;
		logic [2:0]  event_res;
		logic [15:0] probe_count;
	} result_t;

endpackage

// ===== design/mlis_step.sv =====
module mlis_step (
	input  mlis_pkg::cfg_t    cfg,
	input  mlis_pkg::state_t  st,
	input  logic              op,
	input  logic [3:0]        frame_kind,
	input  logic              tx_space,
	output mlis_pkg::state_t  nxt,
	output mlis_pkg::result_t res
);

	logic [31:0] cur_inc;
	logic [31:0] tick_gap;
	logic [31:0] tick_timeout;
	logic [31:0] frame_gap;
	logic [31:0] dl_diff;
	logic [31:0] nx_diff;
	logic [15:0] cmd_arg_sel;
	logic [2:0]  wait_sel;
	logic        match;

	// time arithmetic
	assign cur_inc      = st.cur_time + 32'd1;
	assign tick_gap     = cur_inc + {16'd0, cfg.gap};
	assign tick_timeout = cur_inc + {16'd0, cfg.timeout};
	assign frame_gap    = st.cur_time + {16'd0, cfg.gap};
	assign dl_diff      = cur_inc - st.deadline;
	assign nx_diff      = cur_inc - st.next_time;

	// command argument and reply wait per step
	always_comb begin
		unique case (st.step[2:0])
			mlis_pkg::CMD_TYPE: begin
				cmd_arg_sel = {8'd0, cfg.motor_type};
				wait_sel    = mlis_pkg::WAIT_CFG_OK;
			end
			mlis_pkg::CMD_LINES: begin
				cmd_arg_sel = cfg.line_count;
				wait_sel    = mlis_pkg::WAIT_CFG_OK;
			end
			mlis_pkg::CMD_GEAR: begin
				cmd_arg_sel = cfg.gear_ratio;
				wait_sel    = mlis_pkg::WAIT_CFG_OK;
			end
			mlis_pkg::CMD_DIAMETER: begin
				cmd_arg_sel = cfg.wheel_diameter;
				wait_sel    = mlis_pkg::WAIT_CFG_OK;
			end
			mlis_pkg::CMD_READ_FLASH: begin
				cmd_arg_sel = 16'd0;
				wait_sel    = mlis_pkg::WAIT_FLASH_OK;
			end
			mlis_pkg::CMD_READ_VOLTAGE: begin
				cmd_arg_sel = 16'd0;
				wait_sel    = mlis_pkg::WAIT_BATTERY;
			end
			mlis_pkg::CMD_UPLOAD: begin
				cmd_arg_sel = mlis_pkg::UPLOAD_FLAGS;
				wait_sel    = mlis_pkg::WAIT_UPLOAD;
			end
			mlis_pkg::CMD_ZERO_PWM: begin
				cmd_arg_sel = 16'd0;
				wait_sel    = mlis_pkg::WAIT_NONE;
			end
		endcase
	end

	// does the frame answer the current wait
	always_comb begin
		unique case (st.waiting)
			mlis_pkg::WAIT_CFG_OK,
			mlis_pkg::WAIT_FLASH_OK: match = (frame_kind == mlis_pkg::FK_OK);
			mlis_pkg::WAIT_BATTERY:  match = (frame_kind == mlis_pkg::FK_BATTERY);
			mlis_pkg::WAIT_UPLOAD:   match = (frame_kind == mlis_pkg::FK_OK)
				|| (frame_kind == mlis_pkg::FK_PULSES) || (frame_kind == mlis_pkg::FK_SPEEDS)
				|| (frame_kind == mlis_pkg::FK_BATTERY) || (frame_kind == mlis_pkg::FK_ALL);
			default:                 match = 1'b0;
		endcase
	end

	// next state and command for one item
	always_comb begin
		nxt = st;
		res = '0;
		if (op == mlis_pkg::OP_TICK) begin
			nxt.cur_time = cur_inc;
			if (st.waiting != mlis_pkg::WAIT_NONE) begin
				// reply overdue: back to the probe
				if (!dl_diff[31]) begin
					nxt.waiting   = mlis_pkg::WAIT_NONE;
					nxt.step      = mlis_pkg::STEP_PROBE;
					nxt.next_time = cur_inc;
					res.event_res = mlis_pkg::EV_TIMEOUT;
				end
			end else if (!nx_diff[31] && (st.step < mlis_pkg::STEP_RUNNING)) begin
				if (st.step == mlis_pkg::STEP_PROBE) begin
					// link probe, counted even when dropped
					if (st.probes != 16'hFFFF) begin
						nxt.probes = st.probes + 16'd1;
					end
					if (tx_space) begin
						res.cmd_valid = 1'b1;
						res.cmd_code  = mlis_pkg::CMD_ZERO_PWM;
						nxt.step      = mlis_pkg::STEP_TYPE;
						nxt.next_time = tick_gap;
					end else begin
						nxt.next_time = tick_timeout;
					end
				end else if (!tx_space) begin
					// dropped command: fail, stop also dropped
					nxt.waiting   = mlis_pkg::WAIT_NONE;
					nxt.step      = mlis_pkg::STEP_FAILED;
					res.event_res = mlis_pkg::EV_FAIL_TX;
				end else begin
					res.cmd_valid = 1'b1;
					res.cmd_code  = st.step[2:0];
					res.cmd_arg   = cmd_arg_sel;
					nxt.waiting   = wait_sel;
					nxt.deadline  = tick_timeout;
				end
			end
		end else if (st.waiting != mlis_pkg::WAIT_NONE) begin
			if (frame_kind == mlis_pkg::FK_NACK) begin
				// nack: stop command when tx_space allows it, and terminal failure
				res.cmd_valid = tx_space;
				res.cmd_code  = mlis_pkg::CMD_ZERO_PWM;
				nxt.waiting   = mlis_pkg::WAIT_NONE;
				nxt.step      = mlis_pkg::STEP_FAILED;
				res.event_res = mlis_pkg::EV_FAIL_NACK;
			end else if (match) begin
				nxt.waiting   = mlis_pkg::WAIT_NONE;
				nxt.deadline  = st.cur_time;
				nxt.step      = st.step + 4'd1;
				nxt.next_time = frame_gap;
				res.event_res = mlis_pkg::EV_ADVANCED;
			end
		end
		res.step_now    = nxt.step;
		res.wait_now    = nxt.waiting;
		res.probe_count = nxt.probes;
	end

endmodule

// ===== design/motor_link_init_sequencer_core.sv =====
// Link bring-up sequencer for a motor-controller serial link.
// Input channel (in_valid/in_ready): op selects a time tick or a received
// reply frame; frame_kind and tx_space come with the item. Every item gives
// exactly one result on the output channel (out_valid/out_ready): the
// command issued, if any, the step and wait after the item, the event and
// the probe count.
// A result is registered in the output buffer once its item is taken.
// Throughput: one item per cycle while in_ready is high; the state update
// is a single pass of compares and 32-bit adders between the state registers.
// The output side is a two-entry buffer: with out_ready low, one more item
// is still taken into the skid entry, then in_ready drops until the
// receiver drains it. No result is lost or repeated.
// Configuration (cfg_we/cfg_idx/cfg_wdata) has no handshake; unknown
// indexes are ignored. The user must write it only while the block is idle (unchecked).
// Reset clears time, step, wait and probe count, loads the default
// register values and empties the output buffer.
`include "motor_link_init_sequencer_core_assert.svh"

module motor_link_init_sequencer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mlis_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mlis_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [3:0]                      frame_kind,
	input  logic                            tx_space,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            cmd_valid,
	output logic [2:0]                      cmd_code,
	output logic [15:0]                     cmd_arg,
	output logic [3:0]                      step_now,
	output logic [2:0]                      wait_now,
	output logic [2:0]                      event_res,
	output logic [15:0]                     probe_count
);

	mlis_pkg::cfg_t    cfg_q;
	mlis_pkg::state_t  state_q;
	mlis_pkg::state_t  state_nxt;
	mlis_pkg::result_t res_nxt;
	mlis_pkg::result_t out_q;
	mlis_pkg::result_t skid_q;
	logic              out_v_q;
	logic              skid_v_q;
	logic              in_acc;
	logic              out_free;

	assign in_ready = !skid_v_q;
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_v_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap            <= mlis_pkg::GAP_RST;
			cfg_q.timeout        <= mlis_pkg::TIMEOUT_RST;
			cfg_q.motor_type     <= mlis_pkg::MOTOR_TYPE_RST;
			cfg_q.line_count     <= mlis_pkg::LINE_COUNT_RST;
			cfg_q.gear_ratio     <= mlis_pkg::GEAR_RATIO_RST;
			cfg_q.wheel_diameter <= mlis_pkg::WHEEL_DIAM_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mlis_pkg::CFG_GAP:        cfg_q.gap            <= cfg_wdata;
				mlis_pkg::CFG_TIMEOUT:    cfg_q.timeout        <= cfg_wdata;
				mlis_pkg::CFG_MOTOR_TYPE: cfg_q.motor_type     <= cfg_wdata[7:0];
				mlis_pkg::CFG_LINE_COUNT: cfg_q.line_count     <= cfg_wdata;
				mlis_pkg::CFG_GEAR_RATIO: cfg_q.gear_ratio     <= cfg_wdata;
				mlis_pkg::CFG_WHEEL_DIAM: cfg_q.wheel_diameter <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer step logic
	mlis_step u_step (
		.cfg        (cfg_q),
		.st         (state_q),
		.op         (op),
		.frame_kind (frame_kind),
		.tx_space   (tx_space),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || in_acc;
			skid_v_q <= 1'b0;
		end else if (in_acc) begin
			skid_v_q <= 1'b1;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= res_nxt;
			end
		end else if (in_acc) begin
			skid_q <= res_nxt;
		end
	end

	assign out_valid   = out_v_q;
	assign cmd_valid   = out_q.cmd_valid;
	assign cmd_code    = out_q.cmd_code;
	assign cmd_arg     = out_q.cmd_arg;
	assign step_now    = out_q.step_now;
	assign wait_now    = out_q.wait_now;
	assign event_res   = out_q.event_res;
	assign probe_count = out_q.probe_count;

	// checks
	`MLIS_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q)
	`MLIS_ASSERT_IMP(a_wait_in_cmd_step, state_q.waiting != mlis_pkg::WAIT_NONE,
		(state_q.step >= mlis_pkg::STEP_TYPE) && (state_q.step <= mlis_pkg::STEP_UPLOAD))
	`MLIS_ASSERT_NXT(a_failed_sticks, state_q.step == mlis_pkg::STEP_FAILED,
		state_q.step == mlis_pkg::STEP_FAILED)
	`MLIS_ASSERT_NXT(a_probes_monotonic, 1'b1, state_q.probes >= $past(state_q.probes))
	`MLIS_ASSERT_IMP(a_idle_cmd_zero, out_v_q && !out_q.cmd_valid,
		(out_q.cmd_code == mlis_pkg::CMD_ZERO_PWM) && (out_q.cmd_arg == 16'd0))

endmodule
